/* rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while reset is low
`define HTFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define HTFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/htfd_pkg.sv */
// shared types, constants and the crc step of the frame decoder
package htfd_pkg;

  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'hFF;

  // scaling constants, exact integer form of the conversion formulas
  localparam logic [30:0] TempSpan   = 31'd17500;
  localparam logic [31:0] TempOffset = 32'd294907500;  // 4500 * 65535
  localparam logic [29:0] HumSpan    = 30'd10000;
  localparam logic [16:0] FullScale  = 17'd65535;
  localparam logic [16:0] FullScale2 = 17'd131070;
  localparam logic [26:0] Recip100   = 27'd5243;       // 2^19 / 100, rounded up
  localparam int unsigned Recip100Shift = 19;
  localparam logic [6:0]  Hundred    = 7'd100;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic        crc_ok;
    logic [15:0] temp_word;
    logic [15:0] hum_word;
  } htfd_job_t;

  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/htfd_byte_if.sv */
// request channel carrying one received frame byte
interface htfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source(output valid, output data_byte, output frame_start, input ready);
  modport sink(input valid, input data_byte, input frame_start, output ready);
endinterface

/* rtl/htfd_result_if.sv */
// request channel carrying one decoded measurement
interface htfd_result_if;
  logic              valid;
  logic              ready;
  logic              crc_ok;
  logic signed [8:0] temp_whole;
  logic [6:0]        temp_frac;
  logic [6:0]        hum_whole;
  logic [6:0]        hum_frac;

  modport source(output valid, output crc_ok, output temp_whole, output temp_frac,
                 output hum_whole, output hum_frac, input ready);
  modport sink(input valid, input crc_ok, input temp_whole, input temp_frac,
               input hum_whole, input hum_frac, output ready);
endinterface

/* rtl/htfd_front.sv */
// frame parser: byte position, crc check and raw word assembly
module htfd_front (
  input  logic                clk,
  input  logic                rst,
  htfd_byte_if.sink           frame_bytes,
  output logic                job_push,
  output htfd_pkg::htfd_job_t job,
  input  logic                job_ready
);

  typedef enum logic [2:0] {
    POS_TEMP_MSB,
    POS_TEMP_LSB,
    POS_TEMP_CRC,
    POS_HUM_MSB,
    POS_HUM_LSB,
    POS_HUM_CRC
  } pos_t;

  pos_t        pos, pos_next, pos_eff;
  logic [7:0]  crc, crc_next, crc_eff;
  logic [15:0] temp_word, temp_word_next;
  logic [15:0] hum_word, hum_word_next;
  logic        temp_pass, temp_pass_next;
  logic        accept;
  logic [7:0]  b;

  assign frame_bytes.ready = job_ready;
  assign accept = frame_bytes.valid && frame_bytes.ready;
  assign b      = frame_bytes.data_byte;

  always_comb begin
    // a start mark or a stray position restarts the frame
    if (frame_bytes.frame_start || (pos > POS_HUM_CRC)) begin
      pos_eff = POS_TEMP_MSB;
      crc_eff = htfd_pkg::CrcInit;
    end else begin
      pos_eff = pos;
      crc_eff = crc;
    end

    pos_next       = pos;
    crc_next       = crc;
    temp_word_next = temp_word;
    hum_word_next  = hum_word;
    temp_pass_next = temp_pass;
    job_push       = 1'b0;

    if (accept) begin
      case (pos_eff)
        POS_TEMP_MSB: begin
          crc_next       = htfd_pkg::crc8_update(crc_eff, b);
          temp_word_next = {b, temp_word[7:0]};
          pos_next       = POS_TEMP_LSB;
        end
        POS_TEMP_LSB: begin
          crc_next       = htfd_pkg::crc8_update(crc_eff, b);
          temp_word_next = {temp_word[15:8], b};
          pos_next       = POS_TEMP_CRC;
        end
        POS_TEMP_CRC: begin
          temp_pass_next = (crc_eff == b);
          crc_next       = htfd_pkg::CrcInit;
          pos_next       = POS_HUM_MSB;
        end
        POS_HUM_MSB: begin
          crc_next      = htfd_pkg::crc8_update(crc_eff, b);
          hum_word_next = {b, hum_word[7:0]};
          pos_next      = POS_HUM_LSB;
        end
        POS_HUM_LSB: begin
          crc_next      = htfd_pkg::crc8_update(crc_eff, b);
          hum_word_next = {hum_word[15:8], b};
          pos_next      = POS_HUM_CRC;
        end
        default: begin
          job_push = 1'b1;
          crc_next = htfd_pkg::CrcInit;
          pos_next = POS_TEMP_MSB;
        end
      endcase
    end

    job.crc_ok    = temp_pass && (crc_eff == b);
    job.temp_word = temp_word;
    job.hum_word  = hum_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= POS_TEMP_MSB;
      crc       <= htfd_pkg::CrcInit;
      temp_word <= '0;
      hum_word  <= '0;
      temp_pass <= 1'b0;
    end else begin
      pos       <= pos_next;
      crc       <= crc_next;
      temp_word <= temp_word_next;
      hum_word  <= hum_word_next;
      temp_pass <= temp_pass_next;
    end
  end

endmodule

/* rtl/htfd_queue.sv */
// short fifo of completed frames between parser and converter
module htfd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  htfd_pkg::htfd_job_t push_job,
  output logic                not_full,
  input  logic                pop,
  output logic                head_valid,
  output htfd_pkg::htfd_job_t head_job
);

  htfd_pkg::htfd_job_t                  slots [htfd_pkg::QueueDepth];
  logic [htfd_pkg::QueuePtrW-1:0]       wr_ptr, rd_ptr;
  logic [htfd_pkg::QueueCntW-1:0]       count;
  logic                                 do_push, do_pop;

  assign not_full   = (count != htfd_pkg::QueueCntW'(htfd_pkg::QueueDepth));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];
  assign do_push    = push && not_full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == htfd_pkg::QueuePtrW'(htfd_pkg::QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == htfd_pkg::QueuePtrW'(htfd_pkg::QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/htfd_back.sv */
// conversion pipeline: raw words to hundredths, split into whole and fraction
module htfd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  htfd_pkg::htfd_job_t head_job,
  output logic                pop,
  htfd_result_if.source       readings
);

  // floor(x / 65535): x = a*65536 + b = a*65535 + (a + b), and a + b < 2*65535 + 2
  function automatic logic [13:0] div_full_scale(logic [29:0] x);
    logic [16:0] s;
    logic [14:0] q;
    s = {3'b0, x[29:16]} + {1'b0, x[15:0]};
    q = {1'b0, x[29:16]} + ((s >= htfd_pkg::FullScale)  ? 15'd1 : 15'd0)
                         + ((s >= htfd_pkg::FullScale2) ? 15'd1 : 15'd0);
    return q[13:0];
  endfunction

  logic        en;

  logic        s1_v, s2_v, s3_v, s4_v;
  logic        s1_ok, s2_ok, s3_ok, s4_ok;
  logic [30:0] s1_pt;
  logic [29:0] s1_ph, s2_ph;
  logic        s2_neg, s3_neg, s4_neg;
  logic [29:0] s2_mag;
  logic [13:0] s3_tm, s3_h, s4_tm, s4_h;
  logic [7:0]  s4_qt, s4_qh;

  logic [31:0] diff;
  logic [31:0] diff_abs;
  logic [26:0] prod_t, prod_h;
  logic [13:0] rem_t, rem_h;
  logic signed [8:0] whole_t;

  // the whole pipe moves together; frames are at least six bytes apart
  assign en  = !readings.valid || readings.ready;
  assign pop = en && head_valid;

  assign diff     = {1'b0, s1_pt} - htfd_pkg::TempOffset;
  assign diff_abs = diff[31] ? (~diff + 32'd1) : diff;

  assign prod_t = {13'b0, s3_tm} * htfd_pkg::Recip100;
  assign prod_h = {13'b0, s3_h} * htfd_pkg::Recip100;

  assign rem_t   = s4_tm - 14'({7'b0, s4_qt} * {8'b0, htfd_pkg::Hundred});
  assign rem_h   = s4_h - 14'({7'b0, s4_qh} * {8'b0, htfd_pkg::Hundred});
  assign whole_t = s4_neg ? -$signed({1'b0, s4_qt}) : $signed({1'b0, s4_qt});

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ok <= head_job.crc_ok;
      s1_pt <= htfd_pkg::TempSpan * {15'b0, head_job.temp_word};
      s1_ph <= htfd_pkg::HumSpan * {14'b0, head_job.hum_word};

      s2_ok  <= s1_ok;
      s2_neg <= diff[31];
      s2_mag <= diff_abs[29:0];
      s2_ph  <= s1_ph;

      s3_ok  <= s2_ok;
      s3_neg <= s2_neg;
      s3_tm  <= div_full_scale(s2_mag);
      s3_h   <= div_full_scale(s2_ph);

      s4_ok  <= s3_ok;
      s4_neg <= s3_neg;
      s4_tm  <= s3_tm;
      s4_h   <= s3_h;
      s4_qt  <= prod_t[htfd_pkg::Recip100Shift +: 8];
      s4_qh  <= prod_h[htfd_pkg::Recip100Shift +: 8];

      readings.crc_ok     <= s4_ok;
      readings.temp_whole <= whole_t;
      readings.temp_frac  <= rem_t[6:0];
      readings.hum_whole  <= s4_qh[6:0];
      readings.hum_frac   <= rem_h[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v           <= 1'b0;
      s2_v           <= 1'b0;
      s3_v           <= 1'b0;
      s4_v           <= 1'b0;
      readings.valid <= 1'b0;
    end else if (en) begin
      s1_v           <= head_valid;
      s2_v           <= s1_v;
      s3_v           <= s2_v;
      s4_v           <= s3_v;
      readings.valid <= s4_v;
    end
  end

endmodule

/* rtl/humidity_temperature_frame_decoder_core.sv */
// The decoder takes one frame byte per cycle on frame_bytes (temperature MSB,
// LSB, CRC, then humidity MSB, LSB, CRC) and gives one measurement on readings
// for each completed frame. The parser checks the CRC-8 of each word as bytes
// arrive; a two-entry frame queue hands finished frames to a five-stage
// conversion pipeline ending in the output register. Bytes are taken every
// cycle while the queue has room, so input stalls only when the output has
// been held back long enough to fill the queue.
module humidity_temperature_frame_decoder_core (
  input  logic          clk,
  input  logic          rst,
  htfd_byte_if.sink     frame_bytes,
  htfd_result_if.source readings
);

  logic                job_push;
  htfd_pkg::htfd_job_t job;
  logic                q_not_full;
  logic                q_pop;
  logic                q_head_valid;
  htfd_pkg::htfd_job_t q_head_job;

  htfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .frame_bytes(frame_bytes),
    .job_push   (job_push),
    .job        (job),
    .job_ready  (q_not_full)
  );

  htfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_job  (job),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .head_valid(q_head_valid),
    .head_job  (q_head_job)
  );

  htfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(q_head_valid),
    .head_job  (q_head_job),
    .pop       (q_pop),
    .readings  (readings)
  );

endmodule

/* rtl/htfd_checker.sv */
// port-level checks of the decoder output, bound to the top level
`include "assert_macros.svh"

module htfd_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [8:0] temp_whole,
  input logic [6:0]        temp_frac,
  input logic [6:0]        hum_whole,
  input logic [6:0]        hum_frac
);

  `HTFD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "stalled result dropped")
  `HTFD_ASSERT(a_frac_range, out_valid |-> (temp_frac < 7'd100) && (hum_frac < 7'd100), "fraction out of range")
  `HTFD_ASSERT(a_hum_range, out_valid |-> (hum_whole <= 7'd100) && !((hum_whole == 7'd100) && (hum_frac != 7'd0)), "humidity above full scale")
  `HTFD_ASSERT(a_temp_range, out_valid |-> (temp_whole >= -9'sd45) && (temp_whole <= 9'sd130), "temperature out of range")
  `HTFD_ASSERT_ALWAYS(a_reset_quiet, rst |=> !out_valid, "result after reset")

endmodule

bind humidity_temperature_frame_decoder_core htfd_checker u_htfd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (readings.valid),
  .out_ready (readings.ready),
  .temp_whole(readings.temp_whole),
  .temp_frac (readings.temp_frac),
  .hum_whole (readings.hum_whole),
  .hum_frac  (readings.hum_frac)
);
